FILE: sv/wpsp_pkg.sv
// Package for the world point to screen projection block.
// Holds fixed-point widths, register indexes and shared types; no dependencies.
`default_nettype none
package wpsp_pkg;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned PixW    = 24;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned ClipW   = 66;
  localparam int unsigned RatioW  = 42;   // sign + 41 bit magnitude
  localparam int unsigned DivW    = 23 + 18; // quotient bits produced
  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW   = 6;
  localparam logic [ClipW-1:0] WMinFixed = ClipW'(42950);
  localparam logic signed [PixW+1:0] PixMax = 26'sd8388607;
  localparam logic signed [PixW+1:0] PixMin = -26'sd8388608;

  typedef enum logic [2:0] {
    REG_ROW_X_01 = 3'd0, REG_ROW_X_23 = 3'd1, REG_ROW_Y_01 = 3'd2, REG_ROW_Y_23 = 3'd3,
    REG_ROW_W_01 = 3'd4, REG_ROW_W_23 = 3'd5, REG_ORIGIN = 3'd6, REG_EXTENT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] world_x;
    logic signed [CoordW-1:0] world_y;
    logic signed [CoordW-1:0] world_z;
  } point_t;

  typedef struct packed {
    logic               in_front;
    logic signed [PixW-1:0] pixel_x;
    logic signed [PixW-1:0] pixel_y;
  } pixel_t;

  // front end to back end: clip values
  typedef struct packed {
    logic                     in_front;
    logic signed [ClipW-1:0]  clip_x;
    logic signed [ClipW-1:0]  clip_y;
    logic signed [ClipW-1:0]  clip_w;
  } clip_t;
endpackage
`default_nettype wire

FILE: sv/wpsp_stream_if.sv
// Valid/ready stream interface, generic payload type.
// Depends on nothing.
`default_nettype none
interface wpsp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/wpsp_front.sv
// Front end: world point times three matrix rows, /1000 floor, classifies w.
// Depends on wpsp_pkg. Pipeline of eight stages with valid/ready flow.
`default_nettype none
module wpsp_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [4*32-1:0]        row_x_i,
  input  wire logic [4*32-1:0]        row_y_i,
  input  wire logic [4*32-1:0]        row_w_i,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire wpsp_pkg::point_t       point_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output wpsp_pkg::clip_t             clip_o
);
  import wpsp_pkg::*;
  localparam int unsigned St     = 8;
  localparam int unsigned DigW   = 16;
  localparam int unsigned Digits = 4;
  // one base 2^16 digit per stage: t < 1000*2^16 < 2^26, q = (t*Recip)>>36 is exact
  localparam logic [26:0] Recip    = 27'd68719477;
  localparam logic [25:0] Thousand = 26'd1000;

  logic [St-1:0] vld_q;
  logic          adv;
  assign adv     = !vld_q[St-1] || ready_i;
  assign ready_o = adv;
  assign valid_o = vld_q[St-1];

  // stage 0: products
  logic signed [ProdW-1:0] p_q [3][3];
  logic signed [CoordW-1:0] m3_q [3];
  // stage 1: exact row sum of the three products
  logic signed [ClipW-1:0] sum_q [3];
  logic signed [CoordW-1:0] m3b_q [3];
  // stage 2 (index 0) and digit stages 3..6 (index 1..4): |sum| / 1000
  logic [ProdW-1:0]         mg_q [Digits+1][3];
  logic [ProdW-1:0]         qd_q [Digits+1][3];
  logic [9:0]               rd_q [Digits+1][3];
  logic                     ng_q [Digits+1][3];
  logic signed [CoordW-1:0] m3d_q [Digits+1][3];
  clip_t out_q;

  function automatic logic signed [CoordW-1:0] mword(input logic [4*32-1:0] r, input int k);
    mword = r[k*32 +: 32];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[St-2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    logic [4*32-1:0] rows [3];
    logic signed [CoordW-1:0] v [3];
    logic [25:0] t;
    logic [52:0] pr;
    logic [15:0] qd;
    logic [25:0] rm;
    logic signed [ClipW-1:0] qs;
    logic signed [ClipW-1:0] acc;
    if (adv) begin
      rows[0] = row_x_i; rows[1] = row_y_i; rows[2] = row_w_i;
      v[0] = point_i.world_x; v[1] = point_i.world_y; v[2] = point_i.world_z;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) p_q[r][c] <= ProdW'(mword(rows[r], c) * v[c]);
        m3_q[r] <= mword(rows[r], 3);
      end
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= ClipW'(p_q[r][0]) + ClipW'(p_q[r][1]) + ClipW'(p_q[r][2]);
        m3b_q[r] <= m3_q[r];
      end
      // magnitude of the sum is below 2^64
      for (int r = 0; r < 3; r++) begin
        ng_q[0][r]  <= sum_q[r][ClipW-1];
        mg_q[0][r]  <= sum_q[r][ClipW-1] ? ProdW'(-sum_q[r]) : ProdW'(sum_q[r]);
        qd_q[0][r]  <= '0;
        rd_q[0][r]  <= '0;
        m3d_q[0][r] <= m3b_q[r];
      end
      // long division by 1000, most significant digit first
      for (int j = 1; j <= Digits; j++) begin
        for (int r = 0; r < 3; r++) begin
          t  = {rd_q[j-1][r], mg_q[j-1][r][(Digits-j)*DigW +: DigW]};
          pr = 53'(t) * 53'(Recip);
          qd = pr[51:36];
          rm = t - 26'(qd) * Thousand;
          rd_q[j][r]  <= rm[9:0];
          qd_q[j][r]  <= {qd_q[j-1][r][ProdW-DigW-1:0], qd};
          mg_q[j][r]  <= mg_q[j-1][r];
          ng_q[j][r]  <= ng_q[j-1][r];
          m3d_q[j][r] <= m3d_q[j-1][r];
        end
      end
      // floor for a negative sum, then add column 3 scaled to 32 fraction bits
      for (int r = 0; r < 3; r++) begin
        qs = $signed({2'b00, qd_q[Digits][r]});
        if (ng_q[Digits][r]) begin
          qs = -qs;
          if (rd_q[Digits][r] != 10'd0) qs = qs - ClipW'(1);
        end
        acc = qs + (ClipW'(m3d_q[Digits][r]) <<< 8);
        if (r == 0) out_q.clip_x <= acc;
        else if (r == 1) out_q.clip_y <= acc;
        else begin
          out_q.clip_w   <= acc;
          out_q.in_front <= !acc[ClipW-1] && (acc >= $signed(WMinFixed));
        end
      end
    end
  end
  assign clip_o = out_q;
endmodule
`default_nettype wire

FILE: sv/wpsp_fifo.sv
// Short two-entry queue between front and back end.
// Depends on wpsp_pkg.
`default_nettype none
module wpsp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire wpsp_pkg::clip_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output wpsp_pkg::clip_t      data_o
);
  import wpsp_pkg::*;
  clip_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign push = valid_i && ready_o;
  assign pop  = valid_o && ready_i;
  assign data_o = mem_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
endmodule
`default_nettype wire

FILE: sv/wpsp_back.sv
// Back end: pipelined restoring divider for (a+w)/w, then viewport map and saturation.
// Depends on wpsp_pkg. One quotient bit per stage, two axes in parallel.
`default_nettype none
module wpsp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [31:0]     origin_i,
  input  wire logic [31:0]     extent_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire wpsp_pkg::clip_t clip_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output wpsp_pkg::pixel_t     pixel_o
);
  import wpsp_pkg::*;
  // numerator magnitude < 2^67; quotients >= 2^18 clamp, so test that first
  localparam int unsigned NumW = ClipW + 1;
  localparam int unsigned Steps = DivW;     // 41 bit quotient, MSB first
  localparam int unsigned St = Steps + 3;
  localparam logic [RatioW-2:0] UMax = '1;

  logic [St-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[St-1] || ready_i;
  assign ready_o = adv;
  assign valid_o = vld_q[St-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[St-2:0], valid_i};
  end

  logic [NumW-1:0]  pr_q [Steps+1][2];   // partial remainder
  logic [NumW+22:0] dv_q [Steps+1][2];   // dividend bits left (mag << 23)
  logic [DivW-1:0]  qt_q [Steps+1][2];
  logic             ng_q [Steps+1][2];
  logic             bg_q [Steps+1][2];
  logic [ClipW-1:0] wd_q [Steps+1];
  logic             fr_q [Steps+1];

  always_ff @(posedge clk_i) begin
    logic signed [NumW-1:0] n;
    logic [NumW-1:0] mag;
    logic [NumW:0] t;
    logic [NumW+22:0] d;
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        n = NumW'(a == 0 ? clip_i.clip_x : clip_i.clip_y) + NumW'(clip_i.clip_w);
        mag = n[NumW-1] ? NumW'(-n) : NumW'(n);
        ng_q[0][a] <= n[NumW-1];
        bg_q[0][a] <= (NumW+18)'(mag) >= ((NumW+18)'(clip_i.clip_w) << 18);
        // quotient bits above 2^40 only matter when big, so the first
        // NumW-18 dividend bits are absorbed directly into the remainder.
        d = (NumW+23)'(mag) << 23;
        pr_q[0][a] <= NumW'(d >> (DivW));
        dv_q[0][a] <= d << (NumW+23-DivW);
        qt_q[0][a] <= '0;
      end
      wd_q[0] <= clip_i.clip_w;
      fr_q[0] <= clip_i.in_front;
      for (int s = 1; s <= Steps; s++) begin
        for (int a = 0; a < 2; a++) begin
          t = {pr_q[s-1][a], dv_q[s-1][a][NumW+22]};
          if (t >= (NumW+1)'(wd_q[s-1])) begin
            pr_q[s][a] <= NumW'(t - (NumW+1)'(wd_q[s-1]));
            qt_q[s][a] <= {qt_q[s-1][a][DivW-2:0], 1'b1};
          end else begin
            pr_q[s][a] <= NumW'(t);
            qt_q[s][a] <= {qt_q[s-1][a][DivW-2:0], 1'b0};
          end
          dv_q[s][a] <= dv_q[s-1][a] << 1;
          ng_q[s][a] <= ng_q[s-1][a];
          bg_q[s][a] <= bg_q[s-1][a];
        end
        wd_q[s] <= wd_q[s-1];
        fr_q[s] <= fr_q[s-1];
      end
    end
  end

  // stage Steps+1: clamp and multiply by size; stage Steps+2: scale, add origin, saturate
  logic signed [63:0] sp_q [2];
  logic               f1_q;
  pixel_t             out_q;

  always_ff @(posedge clk_i) begin
    logic [RatioW-2:0] m;
    logic [15:0] sz, org;
    logic [63:0] sm;
    logic signed [PixW+1:0] pix [2];
    logic signed [63:0] s;
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        m  = bg_q[Steps][a] ? UMax : qt_q[Steps][a];
        sz = a == 0 ? extent_i[15:0] : extent_i[31:16];
        sm = 64'(sz) * 64'(m);
        sp_q[a] <= ng_q[Steps][a] ? -$signed(sm) : $signed(sm);
      end
      f1_q <= fr_q[Steps];
      for (int a = 0; a < 2; a++) begin
        org = a == 0 ? origin_i[15:0] : origin_i[31:16];
        s = sp_q[a] >>> 16;
        s = s + (64'(org) << 8);
        if (s > 64'(PixMax)) pix[a] = PixMax;
        else if (s < 64'(PixMin)) pix[a] = PixMin;
        else pix[a] = (PixW+2)'(s);
      end
      out_q.in_front <= f1_q;
      out_q.pixel_x  <= f1_q ? PixW'(pix[0]) : '0;
      out_q.pixel_y  <= f1_q ? PixW'(pix[1]) : '0;
    end
  end
  assign pixel_o = out_q;
endmodule
`default_nettype wire

FILE: sv/world_point_screen_projection_top.sv
// World point to canvas pixel projection, top level.
// Pipeline: 8 front-end stages, a two-entry queue and 44 back-end stages, each divider
// stage adding one quotient bit.
// Throughput: one transaction per cycle unless a stalled result freezes the back end.
// Reset: asynchronous active low; clears valid flags and the registers (extent to 1x1).
// Depends on wpsp_pkg, wpsp_stream_if, wpsp_front, wpsp_fifo, wpsp_back.
`default_nettype none
module world_point_screen_projection_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  wpsp_stream_if.sink      point_if,
  wpsp_stream_if.source    pixel_if
);
  import wpsp_pkg::*;

  logic [63:0] regs_q [NumRegs];
  logic [2:0]  idx;
  logic        wr;
  assign idx = paddr[5:3];
  assign wr  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = regs_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++)
        regs_q[i] <= (i == REG_EXTENT) ? 64'h0001_0001 : 64'h0;
    end else if (wr) begin
      if (idx == REG_ORIGIN || idx == REG_EXTENT) regs_q[idx] <= {32'd0, pwdata[31:0]};
      else regs_q[idx] <= pwdata;
    end
  end

  logic  f_vld, f_rdy, q_vld, q_rdy;
  clip_t f_clip, q_clip;
  pixel_t px;

  wpsp_front u_front (
    .clk_i, .rst_ni,
    .row_x_i ({regs_q[REG_ROW_X_23], regs_q[REG_ROW_X_01]}),
    .row_y_i ({regs_q[REG_ROW_Y_23], regs_q[REG_ROW_Y_01]}),
    .row_w_i ({regs_q[REG_ROW_W_23], regs_q[REG_ROW_W_01]}),
    .valid_i (point_if.valid), .ready_o (point_if.ready), .point_i (point_if.payload),
    .valid_o (f_vld), .ready_i (f_rdy), .clip_o (f_clip)
  );

  // queue decouples the fixed-depth front end from the divider
  wpsp_fifo u_fifo (
    .clk_i, .rst_ni,
    .valid_i (f_vld), .ready_o (f_rdy), .data_i (f_clip),
    .valid_o (q_vld), .ready_i (q_rdy), .data_o (q_clip)
  );

  wpsp_back u_back (
    .clk_i, .rst_ni,
    .origin_i (regs_q[REG_ORIGIN][31:0]), .extent_i (regs_q[REG_EXTENT][31:0]),
    .valid_i (q_vld), .ready_o (q_rdy), .clip_i (q_clip),
    .valid_o (pixel_if.valid), .ready_i (pixel_if.ready), .pixel_o (px)
  );
  assign pixel_if.payload = px;

  // a point behind the camera always reports a zero pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_if.valid && !px.in_front |-> px.pixel_x == '0 && px.pixel_y == '0)
    else $error("behind-camera pixel not zero");
  // a stalled result holds while the back end waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_if.valid && !pixel_if.ready |=> pixel_if.valid && $stable(px))
    else $error("result changed under stall");
  // the queue never accepts while the front end has nothing to give
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !f_vld |-> !(f_vld && f_rdy))
    else $error("queue push without valid");
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for world_point_screen_projection_top.
// Depends on wpsp_pkg, wpsp_stream_if and the block's RTL.
module testbench;
  import wpsp_pkg::*;

  localparam int WatchdogLimit = 20000;  // cycles with no transaction at all
  localparam int DrainCycles   = 80;     // front end, queue and divider depth plus margin
  localparam int LongStall     = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  wpsp_stream_if #(.payload_t(point_t)) point_bus ();
  wpsp_stream_if #(.payload_t(pixel_t)) pixel_bus ();

  world_point_screen_projection_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .point_if (point_bus.sink),
    .pixel_if (pixel_bus.source)
  );

  // Shadow of the register file, as the block should hold it.
  logic [63:0] reg_shadow [NumRegs];
  point_t      point_queue [$];
  pixel_t      expected_pixels [$];
  int          mismatches = 0;
  int          points_taken = 0;
  int          idle_cycles = 0;
  logic        point_taken = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Projection predictor. Clip values carry 32 fraction bits; every product
  // is floored after the mm to metre scale, the remainders summed exactly.
  // ---------------------------------------------------------------------------
  function automatic longint clip_of_row(logic [63:0] lo, logic [63:0] hi,
                                         longint x, longint y, longint z);
    int     m [4];
    longint v [3];
    longint prod, quo, rem, quo_sum, rem_sum;
    m[0] = lo[31:0];
    m[1] = lo[63:32];
    m[2] = hi[31:0];
    m[3] = hi[63:32];
    v[0] = x; v[1] = y; v[2] = z;
    quo_sum = 0;
    rem_sum = 0;
    for (int i = 0; i < 3; i++) begin
      prod = longint'(m[i]) * v[i];
      quo  = prod / 1000;
      rem  = prod % 1000;
      if (rem < 0) begin
        rem += 1000;
        quo -= 1;
      end
      quo_sum += quo;
      rem_sum += rem;
    end
    return quo_sum + rem_sum / 1000 + longint'(m[3]) * 256;
  endfunction

  // (a + w) / w in Q23, truncated toward zero, magnitude clamped to 2^41 - 1
  function automatic longint ndc_ratio(longint a, longint w);
    longint          num;
    logic            neg;
    longint unsigned mag, wu, whole, rem, frac, res;
    num   = a + w;
    neg   = num < 0;
    mag   = neg ? longint'(-num) : num;
    wu    = w;
    whole = mag / wu;
    if (whole >= (64'd1 << 18)) begin
      res = (64'd1 << 41) - 1;
    end else begin
      rem  = mag % wu;
      frac = 0;
      for (int i = 0; i < 23; i++) begin
        rem  = rem << 1;
        frac = frac << 1;
        if (rem >= wu) begin
          rem  -= wu;
          frac |= 1;
        end
      end
      res = (whole << 23) | frac;
      if (res > (64'd1 << 41) - 1) res = (64'd1 << 41) - 1;
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic [PixW-1:0] canvas_pixel(logic [15:0] origin, logic [15:0] size,
                                                   longint u);
    longint scaled, pix;
    scaled = longint'({48'd0, size}) * u;
    scaled = scaled >>> 16;  // floor, as for negative values too
    pix    = longint'({48'd0, origin}) * 256 + scaled;
    if (pix > 8388607) pix = 8388607;
    if (pix < -8388608) pix = -8388608;
    return pix[PixW-1:0];
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t res;
    longint cx, cy, cw;
    cx = clip_of_row(reg_shadow[REG_ROW_X_01], reg_shadow[REG_ROW_X_23],
                     p.world_x, p.world_y, p.world_z);
    cy = clip_of_row(reg_shadow[REG_ROW_Y_01], reg_shadow[REG_ROW_Y_23],
                     p.world_x, p.world_y, p.world_z);
    cw = clip_of_row(reg_shadow[REG_ROW_W_01], reg_shadow[REG_ROW_W_23],
                     p.world_x, p.world_y, p.world_z);
    res = '0;
    if (cw >= 42950) begin
      res.in_front = 1'b1;
      res.pixel_x  = canvas_pixel(reg_shadow[REG_ORIGIN][15:0], reg_shadow[REG_EXTENT][15:0],
                                  ndc_ratio(cx, cw));
      res.pixel_y  = canvas_pixel(reg_shadow[REG_ORIGIN][31:16], reg_shadow[REG_EXTENT][31:16],
                                  ndc_ratio(cy, cw));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Point driver: bursts of random length with random gaps between them.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  initial begin
    point_bus.valid   = 1'b0;
    point_bus.payload = '0;
    pixel_bus.ready   = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!point_bus.valid || point_taken)) begin
      if (gap_left > 0) begin
        point_bus.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (point_queue.size() > 0) begin
        point_bus.valid   <= 1'b1;
        point_bus.payload <= point_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          // some bursts run back to back with no gap at all
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        point_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel receiver: its own stall pattern, stepping through four modes in turn, plus one
  // long hold-off once enough points are in so that the block backs up.
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (!hold_done && points_taken >= 400) begin
      hold_done <= 1'b1;
      hold_left <= LongStall;
      pixel_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pixel_bus.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: pixel_bus.ready <= 1'b1;
        1: pixel_bus.ready <= rx_cycle[0];
        2: pixel_bus.ready <= ($urandom_range(0, 9) < 7);
        default: pixel_bus.ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard, sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t want, got;
    point_taken <= point_bus.valid && point_bus.ready;
    if (rst_ni) begin
      if (point_bus.valid && point_bus.ready) begin
        expected_pixels.push_back(project_point(point_bus.payload));
        points_taken <= points_taken + 1;
      end
      if (pixel_bus.valid && pixel_bus.ready) begin
        got = pixel_bus.payload;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel transaction: front=%0b x=%0d y=%0d",
                     got.in_front, got.pixel_x, got.pixel_y);
        end else begin
          want = expected_pixels.pop_front();
          if (got.in_front !== want.in_front || got.pixel_x !== want.pixel_x ||
              got.pixel_y !== want.pixel_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected front=%0b x=%0d y=%0d, got front=%0b x=%0d y=%0d",
                       want.in_front, want.pixel_x, want.pixel_y,
                       got.in_front, got.pixel_x, got.pixel_y);
          end
        end
      end
      // watchdog: counts cycles without any transaction or register access
      if ((point_bus.valid && point_bus.ready) || (pixel_bus.valid && pixel_bus.ready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    reg_shadow[idx] = (idx >= REG_ORIGIN) ? {32'd0, value[31:0]} : value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender pause: nothing pending, nothing outstanding, divider flushed
  task automatic drain_block();
    while (point_queue.size() > 0 || point_bus.valid || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] q24_entry(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [63:0] matrix_pair(logic [31:0] lo, logic [31:0] hi);
    return {hi, lo};
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.world_x = x;
    p.world_y = y;
    p.world_z = z;
    point_queue.push_back(p);
  endtask

  // camera-like matrix for kinds 0 and 1: entries within +-2.0, w row dominated by
  // a positive constant so most points land in front; else random or extreme values
  task automatic program_camera(int kind);
    logic [31:0] w_const;
    w_const = 32'($urandom_range(1, 8)) << 24;
    case (kind)
      0, 1: begin
        write_reg(REG_ROW_X_01, matrix_pair(q24_entry(1 << 25), q24_entry(1 << 25)));
        write_reg(REG_ROW_X_23, matrix_pair(q24_entry(1 << 25), q24_entry(1 << 25)));
        write_reg(REG_ROW_Y_01, matrix_pair(q24_entry(1 << 25), q24_entry(1 << 25)));
        write_reg(REG_ROW_Y_23, matrix_pair(q24_entry(1 << 25), q24_entry(1 << 25)));
        write_reg(REG_ROW_W_01, matrix_pair(q24_entry(1 << 22), q24_entry(1 << 22)));
        write_reg(REG_ROW_W_23, matrix_pair(q24_entry(1 << 22), w_const));
        write_reg(REG_ORIGIN, {16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))});
        // second flavour: zero size on one axis
        if (kind == 0)
          write_reg(REG_EXTENT, {16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000))});
        else
          write_reg(REG_EXTENT, {16'd0, 16'($urandom_range(1, 4000))});
      end
      2: begin
        for (int i = 0; i < NumRegs; i++)
          write_reg(reg_idx_e'(i), {$urandom, $urandom});
      end
      3: begin
        for (int i = 0; i < NumRegs; i++)
          write_reg(reg_idx_e'(i), '1);
      end
      default: begin
        for (int i = 0; i < REG_ORIGIN; i++)
          write_reg(reg_idx_e'(i), {2{32'h7fff_ffff}});
        write_reg(REG_ORIGIN, 32'h0);
        write_reg(REG_EXTENT, 32'hffff_ffff);
      end
    endcase
  endtask

  initial begin
    int kind;
    for (int i = 0; i < NumRegs; i++) reg_shadow[i] = '0;
    reg_shadow[REG_EXTENT] = 64'h0001_0001;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // a few points on the reset register values: w is zero, so all behind
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    add_point(32'h0, 32'h0, 32'h0);
    drain_block();

    // Directed, plain camera: x right, y down, w fixed at 1.0
    write_reg(REG_ROW_X_01, matrix_pair(32'h0100_0000, 32'h0));
    write_reg(REG_ROW_X_23, 64'h0);
    write_reg(REG_ROW_Y_01, matrix_pair(32'h0, 32'hff00_0000));
    write_reg(REG_ROW_Y_23, 64'h0);
    write_reg(REG_ROW_W_01, 64'h0);
    write_reg(REG_ROW_W_23, matrix_pair(32'h0, 32'h0100_0000));
    write_reg(REG_ORIGIN, {16'd50, 16'd100});
    write_reg(REG_EXTENT, {16'd1080, 16'd1920});
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    add_point(32'd256000, -32'sd256000, 32'd1000);     // edges of NDC
    add_point(-32'sd128000, 32'd128000, 32'd0);
    add_point(32'hffff_ffff, 32'h1, 32'h5555_5555);
    drain_block();

    // Directed: w from column 0 only, so the threshold can be hit exactly
    write_reg(REG_ROW_W_01, matrix_pair(32'h1, 32'h0));
    write_reg(REG_ROW_W_23, 64'h0);
    write_reg(REG_ROW_X_01, matrix_pair(32'h7fff_ffff, 32'h0));
    add_point(32'd42950000, 32'h0, 32'h0);  // smallest w in front
    add_point(32'd42949000, 32'h0, 32'h0);  // just behind
    add_point(32'd42949999, 32'h0, 32'h0);
    add_point(-32'sd1, 32'h0, 32'h0);       // negative w
    add_point(32'h7fff_ffff, 32'h0, 32'h0); // tiny w, huge ratio clamps
    drain_block();
    write_reg(REG_EXTENT, 32'h0);           // zero size: pixel equals origin
    add_point(32'd50000000, 32'h0, 32'h0);
    add_point(32'd42950000, 32'h7fff_ffff, 32'h8000_0000);
    drain_block();

    // Random phases over a range of register settings
    for (int phase = 0; phase < 7; phase++) begin
      kind = (phase < 5) ? phase : $urandom_range(0, 2);
      program_camera(kind);
      for (int n = 0; n < 265; n++) begin
        if ($urandom_range(0, 4) == 0)
          add_point($urandom, $urandom, $urandom);
        else
          add_point(q24_entry(5000 * 256), q24_entry(5000 * 256), q24_entry(5000 * 256));
      end
      drain_block();
    end

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: world_point_screen_projection_top.f
sv/wpsp_pkg.sv
sv/wpsp_stream_if.sv
sv/wpsp_front.sv
sv/wpsp_fifo.sv
sv/wpsp_back.sv
sv/world_point_screen_projection_top.sv
tb/sv/testbench.sv
